[sv/zrle_pkg.sv]
// Shared types, sizes and varint helpers for the zero-run / literal-run encoder.
`default_nettype none

package zrle_pkg;

  localparam int unsigned BufferBytes = 65536;
  localparam int unsigned AddrW       = $clog2(BufferBytes);
  localparam int unsigned LenW        = AddrW + 1;
  localparam int unsigned HdrW        = LenW + 3;
  localparam int unsigned LitCap      = 7;

  // Codes of the action field.
  localparam logic ActLoad = 1'b0;
  localparam logic ActPull = 1'b1;

  typedef enum logic [2:0] {
    PhLoad,
    PhScanZero,
    PhScanLit,
    PhHead,
    PhExtra,
    PhLit,
    PhLitRead
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       final_byte;
  } out_item_t;

  // Index of the most significant nonzero 7-bit digit.
  function automatic logic [1:0] top_digit(input logic [HdrW-1:0] v);
    logic [1:0] d;
    d = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if ((v >> (7 * i)) != '0) begin
        d = 2'(i);
      end
    end
    return d;
  endfunction

  function automatic logic [7:0] varint_byte(input logic [HdrW-1:0] v,
                                             input logic [1:0]      digit);
    logic [HdrW-1:0] s;
    s = v >> (7 * int'(digit));
    return {(digit != 2'd0), s[6:0]};
  endfunction

  function automatic logic [HdrW-1:0] header_value(input logic [LenW-1:0] zeros,
                                                   input logic [LenW-1:0] lits);
    logic [2:0] low;
    low = (lits > LenW'(LitCap)) ? 3'(LitCap) : lits[2:0];
    return {zeros, 3'b000} | {{(HdrW - 3){1'b0}}, low};
  endfunction

endpackage

`default_nettype wire

[sv/zero_run_literal_rle_encoder.sv]
// Zero-run / literal-run byte compressor with big-endian varint block headers.
//
//   channel | direction | payload         | handshake
//   in      | input     | zrle_pkg::in_item_t  | in_valid_i / in_stall_o
//   out     | output    | zrle_pkg::out_item_t | out_valid_o / out_stall_i
//
// A load and a pull of a header or excess-count byte are each taken directly; a pull of
// a literal byte passes PhLit and then PhLitRead, since the buffer memory read is registered.
// The closing load and the end of each block that leaves bytes unscanned start a scan
// of the next block, during which the input is stalled.
// Reset clears all counters at once; the buffer memory needs no clearing pass.
// A result that the receiver stalls holds off the input until it is taken.
`default_nettype none

module zero_run_literal_rle_encoder (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire zrle_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output zrle_pkg::out_item_t      out_item_o
);
  import zrle_pkg::*;

  logic [7:0] mem_q [BufferBytes];

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [LenW-1:0] zcnt_q, zcnt_d;
  logic [LenW-1:0] lcnt_q, lcnt_d;
  logic [LenW-1:0] scan_q, scan_d;
  logic [1:0]      digit_q, digit_d;
  logic            rd_valid_q, rd_valid_d;
  logic            prev_zero_q, prev_zero_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q;
  logic [7:0]      rd_data_q;

  out_item_t       res;
  logic            out_load;
  logic            wr_en;
  logic            in_acc, load_acc, pull_acc, busy;
  logic            scan_end, byte_zero, lit_last, pos_done;
  logic [LenW-1:0] pos_inc, ext, rd_sum;
  logic [HdrW-1:0] hdr, ext_hdr;
  logic [AddrW-1:0] rd_addr;

  assign busy = (phase_q == PhScanZero) || (phase_q == PhScanLit) ||
                (phase_q == PhLitRead);
  assign in_stall_o = busy || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (in_item_i.action == ActLoad);
  assign pull_acc   = in_acc && (in_item_i.action == ActPull);

  assign scan_end  = scan_q >= len_q;
  assign byte_zero = rd_data_q == 8'h00;
  assign lit_last  = lcnt_q == LenW'(1);
  assign pos_inc   = pos_q + LenW'(1);
  assign pos_done  = pos_inc >= len_q;
  assign ext       = lcnt_q - LenW'(LitCap);
  assign ext_hdr   = {3'b000, ext};
  assign hdr       = header_value(zcnt_q, lcnt_q);

  // While scanning, the address runs one ahead of the byte being examined.
  assign rd_sum  = scan_q + LenW'(rd_valid_q);
  assign rd_addr = ((phase_q == PhScanZero) || (phase_q == PhScanLit)) ?
                   rd_sum[AddrW-1:0] : pos_q[AddrW-1:0];

  // Writes happen only while loading and scans start the cycle after, so no read whose
  // data is used meets a write to the same entry.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q[AddrW-1:0]] <= in_item_i.data_byte;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PhLoad: begin
        if (load_acc && in_item_i.is_last) begin
          phase_d = PhScanZero;
        end
      end
      PhScanZero: begin
        if (scan_end) begin
          phase_d = PhHead;
        end else if (rd_valid_q && !byte_zero) begin
          phase_d = PhScanLit;
        end
      end
      PhScanLit: begin
        if (scan_end || (rd_valid_q && byte_zero && prev_zero_q)) begin
          phase_d = PhHead;
        end
      end
      PhHead: begin
        if (pull_acc && (digit_q == 2'd0)) begin
          if (lcnt_q >= LenW'(LitCap)) begin
            phase_d = PhExtra;
          end else if (lcnt_q != '0) begin
            phase_d = PhLit;
          end else if (pos_q >= len_q) begin
            phase_d = PhLoad;
          end else begin
            phase_d = PhScanZero;
          end
        end
      end
      PhExtra: begin
        if (pull_acc && (digit_q == 2'd0)) begin
          phase_d = PhLit;
        end
      end
      PhLit: begin
        if (pull_acc) begin
          phase_d = PhLitRead;
        end
      end
      PhLitRead: begin
        if (lit_last) begin
          phase_d = pos_done ? PhLoad : PhScanZero;
        end else begin
          phase_d = PhLit;
        end
      end
      default: phase_d = PhLoad;
    endcase
  end

  always_comb begin
    len_d       = len_q;
    pos_d       = pos_q;
    zcnt_d      = zcnt_q;
    lcnt_d      = lcnt_q;
    scan_d      = scan_q;
    digit_d     = digit_q;
    rd_valid_d  = rd_valid_q;
    prev_zero_d = prev_zero_q;
    res         = '0;
    out_load    = 1'b0;
    wr_en       = 1'b0;
    case (phase_q)
      PhLoad: begin
        if (load_acc) begin
          // Bytes past the end of the buffer are dropped.
          if (len_q < LenW'(BufferBytes)) begin
            wr_en = 1'b1;
            len_d = len_q + LenW'(1);
          end
          if (in_item_i.is_last) begin
            pos_d      = '0;
            scan_d     = '0;
            zcnt_d     = '0;
            lcnt_d     = '0;
            rd_valid_d = 1'b0;
          end
        end
        if (pull_acc) begin
          out_load = 1'b1;
        end
      end
      PhScanZero: begin
        if (scan_end) begin
          pos_d   = scan_q;
          lcnt_d  = '0;
          digit_d = top_digit(header_value(zcnt_q, '0));
        end else if (rd_valid_q) begin
          scan_d = scan_q + LenW'(1);
          if (byte_zero) begin
            zcnt_d = zcnt_q + LenW'(1);
          end else begin
            pos_d       = scan_q;
            lcnt_d      = LenW'(1);
            prev_zero_d = 1'b0;
          end
        end else begin
          rd_valid_d = 1'b1;
        end
      end
      PhScanLit: begin
        if (scan_end) begin
          digit_d = top_digit(header_value(zcnt_q, lcnt_q));
        end else if (rd_valid_q) begin
          if (byte_zero && prev_zero_q) begin
            // Two zeros in a row: the first one belongs to the next block.
            lcnt_d  = lcnt_q - LenW'(1);
            digit_d = top_digit(header_value(zcnt_q, lcnt_q - LenW'(1)));
          end else begin
            lcnt_d      = lcnt_q + LenW'(1);
            prev_zero_d = byte_zero;
            scan_d      = scan_q + LenW'(1);
          end
        end else begin
          rd_valid_d = 1'b1;
        end
      end
      PhHead: begin
        if (pull_acc) begin
          out_load     = 1'b1;
          res.out_byte = varint_byte(hdr, digit_q);
          res.has_byte = 1'b1;
          if (digit_q != 2'd0) begin
            digit_d = digit_q - 2'd1;
          end else if (lcnt_q >= LenW'(LitCap)) begin
            digit_d = top_digit(ext_hdr);
          end else if (lcnt_q == '0) begin
            if (pos_q >= len_q) begin
              res.final_byte = 1'b1;
              len_d          = '0;
              pos_d          = '0;
              zcnt_d         = '0;
              lcnt_d         = '0;
              digit_d        = 2'd0;
            end else begin
              scan_d     = pos_q;
              zcnt_d     = '0;
              lcnt_d     = '0;
              rd_valid_d = 1'b0;
            end
          end
        end
      end
      PhExtra: begin
        if (pull_acc) begin
          out_load     = 1'b1;
          res.out_byte = varint_byte(ext_hdr, digit_q);
          res.has_byte = 1'b1;
          if (digit_q != 2'd0) begin
            digit_d = digit_q - 2'd1;
          end
        end
      end
      PhLitRead: begin
        out_load     = 1'b1;
        res.out_byte = rd_data_q;
        res.has_byte = 1'b1;
        pos_d        = pos_inc;
        lcnt_d       = lcnt_q - LenW'(1);
        if (lit_last) begin
          if (pos_done) begin
            res.final_byte = 1'b1;
            len_d          = '0;
            pos_d          = '0;
            zcnt_d         = '0;
            lcnt_d         = '0;
            digit_d        = 2'd0;
          end else begin
            scan_d     = pos_inc;
            zcnt_d     = '0;
            lcnt_d     = '0;
            rd_valid_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLoad;
      len_q       <= '0;
      pos_q       <= '0;
      zcnt_q      <= '0;
      lcnt_q      <= '0;
      scan_q      <= '0;
      digit_q     <= 2'd0;
      rd_valid_q  <= 1'b0;
      prev_zero_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      zcnt_q      <= zcnt_d;
      lcnt_q      <= lcnt_d;
      scan_q      <= scan_d;
      digit_q     <= digit_d;
      rd_valid_q  <= rd_valid_d;
      prev_zero_q <= prev_zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register loaded while a result still waits");

  a_lit_read_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhLitRead) |-> ($past(phase_q) == PhLit))
    else $error("literal read step without a literal pull");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= len_q)
    else $error("scan position beyond buffer length");

  a_final_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res.final_byte) |=> (phase_q == PhLoad) && (len_q == '0))
    else $error("stream end did not return to loading");

  a_final_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.final_byte) |-> out_q.has_byte)
    else $error("final byte flagged without a valid byte");

endmodule

`default_nettype wire
